// ----- hdl/cbm_pkg.sv -----
// Package for the cartridge bank mapper: command, mapper kind and register index codes,
// plus default widths for the bank registers.
// No dependencies.
package cbm_pkg;

	localparam int ROM_BANK_BITS_DEF = 9;
	localparam int RAM_BANK_BITS_DEF = 4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;

	typedef enum logic [1:0] {
		CMD_ROM_WRITE = 2'd0,
		CMD_ROM_READ  = 2'd1,
		CMD_RAM_WRITE = 2'd2,
		CMD_RAM_READ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_MBC1 = 3'd1,
		KIND_MBC2 = 3'd2,
		KIND_MBC3 = 3'd3,
		KIND_MBC5 = 3'd4
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MAPPER_KIND    = 3'd0,
		CFG_ROM_BANK_MASK  = 3'd1,
		CFG_RAM_BANK_MASK  = 3'd2,
		CFG_CLOCK_PRESENT  = 3'd3,
		CFG_RUMBLE_PRESENT = 3'd4
	} cfg_index_t;

	localparam logic [3:0] RAM_ENABLE_CODE = 4'hA;
	localparam logic [3:0] CLOCK_SEL_FIRST = 4'h8;
	localparam logic [3:0] CLOCK_SEL_LAST  = 4'hC;

endpackage

// ----- hdl/cbm_if.sv -----
// Valid/ready channel interfaces for the cartridge bank mapper: bus accesses in, results out.
// Depends on nothing; payload widths are fixed by the bus and memory maps.
interface cbm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] bus_address;
	logic [7:0]  bus_data;

	modport source (output valid, command, bus_address, bus_data, input ready);
	modport sink (input valid, command, bus_address, bus_data, output ready);
endinterface

interface cbm_out_if;
	logic        valid;
	logic        ready;
	logic [22:0] rom_address;
	logic [16:0] ram_address;
	logic        rom_read;
	logic        ram_read;
	logic        ram_write;
	logic [7:0]  store_data;
	logic        clock_read;
	logic        clock_write;
	logic        clock_latch;
	logic [2:0]  clock_register;

	modport source (output valid, rom_address, ram_address, rom_read, ram_read, ram_write,
		store_data, clock_read, clock_write, clock_latch, clock_register, input ready);
	modport sink (input valid, rom_address, ram_address, rom_read, ram_read, ram_write,
		store_data, clock_read, clock_write, clock_latch, clock_register, output ready);
endinterface

// ----- hdl/cartridge_bank_mapper_core.sv -----
// Top level of the cartridge bank mapper: input register, bank register update and address
// translation, result register. Depends on cbm_pkg and the channel interfaces in cbm_if.sv.
//
// The mapper takes one bus access beat per clock cycle and returns exactly one result beat
// for each, in order. A beat is held in the input register, where the mapper registers are
// updated and the physical address is formed, and is then delivered from the result
// register. A stall on the result side holds both registers and backs up into the input
// handshake. Configuration writes must only be issued while no accepted beat is still
// waiting for delivery.
module cartridge_bank_mapper_core #(
	parameter int ROM_BANK_BITS = cbm_pkg::ROM_BANK_BITS_DEF,
	parameter int RAM_BANK_BITS = cbm_pkg::RAM_BANK_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [cbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	cbm_in_if.sink                         in_ch,
	cbm_out_if.source                      out_ch
);

	logic [2:0] mapper_kind_q;
	logic [8:0] rom_bank_mask_q;
	logic [3:0] ram_bank_mask_q;
	logic       clock_present_q;
	logic       rumble_present_q;

	logic [ROM_BANK_BITS-1:0] rom_bank_q, rom_bank_d;
	logic [7:0]               rom_bank_low_q, rom_bank_low_d;
	logic [8:0]               rom_bank_high_q, rom_bank_high_d;
	logic                     banking_mode_q, banking_mode_d;
	logic [3:0]               ram_select_q, ram_select_d;
	logic [RAM_BANK_BITS-1:0] ram_mapped_bank_q, ram_mapped_bank_d;
	logic                     last_latch_zero_q, last_latch_zero_d;
	logic                     ram_enabled_q, ram_enabled_d;

	logic               valid_s1;
	cbm_pkg::cmd_t      cmd_s1;
	logic [15:0]        addr_s1;
	logic [7:0]         data_s1;

	logic               valid_s2;
	logic [22:0]        rom_address_s2;
	logic [16:0]        ram_address_s2;
	logic               rom_read_s2;
	logic               ram_read_s2;
	logic               ram_write_s2;
	logic [7:0]         store_data_s2;
	logic               clock_read_s2;
	logic               clock_write_s2;
	logic               clock_latch_s2;
	logic [2:0]         clock_register_s2;

	logic        advance;
	logic [3:0]  region;
	logic        enable_code;
	logic        clock_selected;
	logic        gated;
	logic [16:0] ram_addr;
	logic [3:0]  ram_bank_sel;

	logic [22:0] rom_address_d;
	logic [16:0] ram_address_d;
	logic        rom_read_d;
	logic        ram_read_d;
	logic        ram_write_d;
	logic [7:0]  store_data_d;
	logic        clock_read_d;
	logic        clock_write_d;
	logic        clock_latch_d;
	logic [2:0]  clock_register_d;

	function automatic logic [8:0] mbc1_bank(input logic mode, input logic [8:0] low,
		input logic [8:0] high, input logic [8:0] mask);
		logic [8:0] b;
		b = (mode ? low : (high | low)) & mask;
		if (b[4:0] == 5'd0) begin
			b = b + 9'd1;
		end
		return b;
	endfunction

	function automatic logic [8:0] nonzero_bank(input logic [7:0] d, input logic [8:0] mask);
		logic [8:0] b;
		b = {1'b0, d} & mask;
		if (b == 9'd0) begin
			b = 9'd1;
		end
		return b;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_kind_q    <= cbm_pkg::KIND_NONE;
			rom_bank_mask_q  <= 9'd1;
			ram_bank_mask_q  <= 4'd0;
			clock_present_q  <= 1'b0;
			rumble_present_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cbm_pkg::CFG_MAPPER_KIND:    mapper_kind_q    <= cfg_data[2:0];
				cbm_pkg::CFG_ROM_BANK_MASK:  rom_bank_mask_q  <= cfg_data[8:0];
				cbm_pkg::CFG_RAM_BANK_MASK:  ram_bank_mask_q  <= cfg_data[3:0];
				cbm_pkg::CFG_CLOCK_PRESENT:  clock_present_q  <= cfg_data[0];
				cbm_pkg::CFG_RUMBLE_PRESENT: rumble_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_s1  <= cbm_pkg::cmd_t'(in_ch.command);
			addr_s1 <= in_ch.bus_address;
			data_s1 <= in_ch.bus_data;
		end
	end

	assign region       = addr_s1[15:12];
	assign enable_code  = data_s1[3:0] == cbm_pkg::RAM_ENABLE_CODE;
	assign gated        = mapper_kind_q == cbm_pkg::KIND_MBC1 || mapper_kind_q == cbm_pkg::KIND_MBC2
		|| mapper_kind_q == cbm_pkg::KIND_MBC3 || mapper_kind_q == cbm_pkg::KIND_MBC5;
	assign clock_selected = mapper_kind_q == cbm_pkg::KIND_MBC3 && clock_present_q
		&& ram_select_q >= cbm_pkg::CLOCK_SEL_FIRST && ram_select_q <= cbm_pkg::CLOCK_SEL_LAST;
	assign ram_bank_sel = (rumble_present_q ? {1'b0, data_s1[2:0]} : data_s1[3:0])
		& ram_bank_mask_q;

	always_comb begin
		if (mapper_kind_q == cbm_pkg::KIND_MBC2) begin
			ram_addr = {8'd0, addr_s1[8:0]};
		end else begin
			ram_addr = (17'(ram_mapped_bank_q) << 13) | 17'(addr_s1[12:0]);
		end
	end

	// Bank register update for a ROM-area write.
	always_comb begin
		rom_bank_d        = rom_bank_q;
		rom_bank_low_d    = rom_bank_low_q;
		rom_bank_high_d   = rom_bank_high_q;
		banking_mode_d    = banking_mode_q;
		ram_select_d      = ram_select_q;
		ram_mapped_bank_d = ram_mapped_bank_q;
		last_latch_zero_d = last_latch_zero_q;
		ram_enabled_d     = ram_enabled_q;
		clock_latch_d     = 1'b0;
		if (cmd_s1 == cbm_pkg::CMD_ROM_WRITE) begin
			case (mapper_kind_q)
				cbm_pkg::KIND_MBC1: begin
					if (region <= 4'd1) begin
						ram_enabled_d = enable_code;
					end else if (region <= 4'd3) begin
						rom_bank_low_d = {3'd0, data_s1[4:0]};
						rom_bank_d = ROM_BANK_BITS'(mbc1_bank(banking_mode_q,
							{4'd0, data_s1[4:0]}, rom_bank_high_q, rom_bank_mask_q));
					end else if (region <= 4'd5) begin
						if (banking_mode_q) begin
							ram_select_d      = data_s1[3:0] & ram_bank_mask_q;
							ram_mapped_bank_d = RAM_BANK_BITS'(data_s1[3:0] & ram_bank_mask_q);
						end else begin
							rom_bank_high_d = 9'(data_s1[1:0]) << 5;
							rom_bank_d = ROM_BANK_BITS'(mbc1_bank(banking_mode_q,
								{1'b0, rom_bank_low_q}, 9'(data_s1[1:0]) << 5,
								rom_bank_mask_q));
						end
					end else if (region <= 4'd7) begin
						banking_mode_d = data_s1[0];
					end
				end
				cbm_pkg::KIND_MBC2: begin
					if (!addr_s1[15] && !addr_s1[14]) begin
						if (!addr_s1[8]) begin
							ram_enabled_d = enable_code;
						end else begin
							rom_bank_d = ROM_BANK_BITS'(nonzero_bank(data_s1, rom_bank_mask_q));
						end
					end
				end
				cbm_pkg::KIND_MBC3: begin
					if (region <= 4'd1) begin
						ram_enabled_d = enable_code;
					end else if (region <= 4'd3) begin
						rom_bank_d = ROM_BANK_BITS'(nonzero_bank(data_s1, rom_bank_mask_q));
					end else if (region <= 4'd5) begin
						if (clock_present_q && data_s1 >= 8'(cbm_pkg::CLOCK_SEL_FIRST)
							&& data_s1 <= 8'(cbm_pkg::CLOCK_SEL_LAST)) begin
							ram_select_d = data_s1[3:0];
						end else begin
							ram_select_d      = data_s1[3:0] & ram_bank_mask_q;
							ram_mapped_bank_d = RAM_BANK_BITS'(data_s1[3:0] & ram_bank_mask_q);
						end
					end else if (region <= 4'd7) begin
						if (clock_present_q) begin
							clock_latch_d     = last_latch_zero_q && data_s1 == 8'd1;
							last_latch_zero_d = data_s1 == 8'd0;
						end
					end
				end
				cbm_pkg::KIND_MBC5: begin
					if (region <= 4'd1) begin
						ram_enabled_d = enable_code;
					end else if (region == 4'd2) begin
						rom_bank_low_d = data_s1;
						rom_bank_d = ROM_BANK_BITS'(({1'b0, data_s1} | rom_bank_high_q)
							& rom_bank_mask_q);
					end else if (region == 4'd3) begin
						rom_bank_high_d = {data_s1[0], 8'd0};
						rom_bank_d = ROM_BANK_BITS'(({1'b0, rom_bank_low_q} | {data_s1[0], 8'd0})
							& rom_bank_mask_q);
					end else if (region <= 4'd5) begin
						ram_select_d      = ram_bank_sel;
						ram_mapped_bank_d = RAM_BANK_BITS'(ram_bank_sel);
					end
				end
				default: ;
			endcase
		end
	end

	// Result for the beat in the input register, formed from the registers before its update.
	always_comb begin
		rom_address_d    = 23'd0;
		ram_address_d    = 17'd0;
		rom_read_d       = 1'b0;
		ram_read_d       = 1'b0;
		ram_write_d      = 1'b0;
		store_data_d     = 8'd0;
		clock_read_d     = 1'b0;
		clock_write_d    = 1'b0;
		clock_register_d = 3'd0;
		unique case (cmd_s1)
			cbm_pkg::CMD_ROM_WRITE: ;
			cbm_pkg::CMD_ROM_READ: begin
				rom_read_d = 1'b1;
				if (!addr_s1[14]) begin
					rom_address_d = 23'(addr_s1[13:0]);
				end else begin
					rom_address_d = (23'(rom_bank_q) << 14) | 23'(addr_s1[13:0]);
				end
			end
			cbm_pkg::CMD_RAM_WRITE: begin
				if (!gated || ram_enabled_q) begin
					if (clock_selected) begin
						clock_write_d    = 1'b1;
						clock_register_d = ram_select_q[2:0];
						store_data_d     = data_s1;
					end else begin
						ram_write_d   = 1'b1;
						ram_address_d = ram_addr;
						store_data_d  = (mapper_kind_q == cbm_pkg::KIND_MBC2)
							? {4'd0, data_s1[3:0]} : data_s1;
					end
				end
			end
			cbm_pkg::CMD_RAM_READ: begin
				if (clock_selected) begin
					clock_read_d     = 1'b1;
					clock_register_d = ram_select_q[2:0];
				end else begin
					ram_read_d    = 1'b1;
					ram_address_d = ram_addr;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q        <= ROM_BANK_BITS'(1);
			rom_bank_low_q    <= 8'd0;
			rom_bank_high_q   <= 9'd0;
			banking_mode_q    <= 1'b0;
			ram_select_q      <= 4'd0;
			ram_mapped_bank_q <= '0;
			last_latch_zero_q <= 1'b0;
			ram_enabled_q     <= 1'b0;
			valid_s2          <= 1'b0;
		end else begin
			if (advance) begin
				rom_bank_q        <= rom_bank_d;
				rom_bank_low_q    <= rom_bank_low_d;
				rom_bank_high_q   <= rom_bank_high_d;
				banking_mode_q    <= banking_mode_d;
				ram_select_q      <= ram_select_d;
				ram_mapped_bank_q <= ram_mapped_bank_d;
				last_latch_zero_q <= last_latch_zero_d;
				ram_enabled_q     <= ram_enabled_d;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rom_address_s2    <= rom_address_d;
			ram_address_s2    <= ram_address_d;
			rom_read_s2       <= rom_read_d;
			ram_read_s2       <= ram_read_d;
			ram_write_s2      <= ram_write_d;
			store_data_s2     <= store_data_d;
			clock_read_s2     <= clock_read_d;
			clock_write_s2    <= clock_write_d;
			clock_latch_s2    <= clock_latch_d;
			clock_register_s2 <= clock_register_d;
		end
	end

	assign out_ch.valid          = valid_s2;
	assign out_ch.rom_address    = rom_address_s2;
	assign out_ch.ram_address    = ram_address_s2;
	assign out_ch.rom_read       = rom_read_s2;
	assign out_ch.ram_read       = ram_read_s2;
	assign out_ch.ram_write      = ram_write_s2;
	assign out_ch.store_data     = store_data_s2;
	assign out_ch.clock_read     = clock_read_s2;
	assign out_ch.clock_write    = clock_write_s2;
	assign out_ch.clock_latch    = clock_latch_s2;
	assign out_ch.clock_register = clock_register_s2;

`ifndef NO_ASSERTIONS
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({rom_read_s2, ram_read_s2, ram_write_s2,
			clock_read_s2, clock_write_s2}))
		else $error("more than one access strobe in one result beat");

	a_latch_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && clock_latch_s2 |-> !last_latch_zero_q)
		else $error("latch pulse delivered while the latch byte still reads zero");

	a_clock_reg_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (clock_read_s2 || clock_write_s2) |-> clock_register_s2 <= 3'd4)
		else $error("clock register select out of range");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(addr_s1) && $stable(data_s1)
			&& $stable(cmd_s1))
		else $error("input register changed while the result side was stalled");
`endif

endmodule
